[src/bpc_pkg.sv]
// Package for the button press classifier: shared constants, codes and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bpc_pkg;

	// Default widths of the time base and of the event counters.
	localparam int TIME_BITS_DEF  = 32;
	localparam int COUNT_BITS_DEF = 16;

	// Threshold registers are fixed at 32 bits.
	localparam int THR_BITS = 32;

	// Configuration port geometry.
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_LOW   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_MAX_MS = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG_MIN_MS  = 2'd2;

	// Configuration reset values.
	localparam logic                ACTIVE_LOW_RST   = 1'b1;
	localparam logic [THR_BITS-1:0] SHORT_MAX_MS_RST = 32'd500;
	localparam logic [THR_BITS-1:0] LONG_MIN_MS_RST  = 32'd1000;

	// Input command codes.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Single-bit status of one result beat.
	typedef struct packed {
		logic long_bumped;
		logic short_bumped;
		logic release_edge;
		logic press_edge;
		logic is_pressed;
	} bpc_flags_t;

endpackage

[src/bpc_core.sv]
// Classifier state and next-state logic for one sample or clear command.
// Depends on bpc_pkg; instantiated by button_press_classifier_unit.
`timescale 1ns / 1ps

module bpc_core import bpc_pkg::*; #(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  command,
	input  logic                  pin_level,
	input  logic                  active_low,
	input  logic [THR_BITS-1:0]   short_max_ms,
	input  logic [THR_BITS-1:0]   long_min_ms,
	output bpc_flags_t            flags,
	output logic [TIME_BITS-1:0]  press_time_ms,
	output logic [TIME_BITS-1:0]  release_time_ms,
	output logic [COUNT_BITS-1:0] press_total,
	output logic [COUNT_BITS-1:0] release_total,
	output logic [COUNT_BITS-1:0] short_total,
	output logic [COUNT_BITS-1:0] long_total
);

	localparam int CMP_W = (TIME_BITS > THR_BITS) ? TIME_BITS : THR_BITS;

	// Current state.
	logic [TIME_BITS-1:0]  now_q;
	logic                  pressed_prev_q;
	logic [TIME_BITS-1:0]  press_start_q;
	logic [TIME_BITS-1:0]  press_end_q;
	logic                  press_run_q;
	logic [TIME_BITS-1:0]  release_start_q;
	logic                  release_run_q;
	logic [COUNT_BITS-1:0] press_cnt_q;
	logic [COUNT_BITS-1:0] release_cnt_q;
	logic [COUNT_BITS-1:0] short_cnt_q;
	logic [COUNT_BITS-1:0] long_cnt_q;
	logic                  short_win_q;
	logic                  long_hold_q;

	// Next state.
	logic                  clear;
	logic                  pressed;
	logic [TIME_BITS-1:0]  now_inc;
	logic [TIME_BITS-1:0]  now_nx;
	logic                  press_edge;
	logic                  release_edge;
	logic                  pressed_prev_nx;
	logic [TIME_BITS-1:0]  press_start_nx;
	logic [TIME_BITS-1:0]  press_end_nx;
	logic                  press_run_nx;
	logic [TIME_BITS-1:0]  release_start_nx;
	logic                  release_run_nx;
	logic [COUNT_BITS-1:0] press_cnt_nx;
	logic [COUNT_BITS-1:0] release_cnt_nx;
	logic [COUNT_BITS-1:0] short_cnt_nx;
	logic [COUNT_BITS-1:0] long_cnt_nx;
	logic                  short_win_nx;
	logic                  long_hold_nx;
	logic [TIME_BITS-1:0]  ptime;
	logic [TIME_BITS-1:0]  rtime;
	logic [COUNT_BITS-1:0] short_kept;
	logic [COUNT_BITS-1:0] long_kept;
	logic                  ge_short;
	logic                  le_short;
	logic                  ge_long;
	logic                  le_long;
	logic                  short_win;
	logic                  long_hold;
	logic                  short_bump;
	logic                  long_bump;

	// Edge detection and timer bookkeeping.
	always_comb begin
		clear        = (command == CMD_CLEAR);
		pressed      = active_low ? ~pin_level : pin_level;
		now_inc      = now_q + TIME_BITS'(1);
		now_nx       = clear ? now_q : now_inc;
		press_edge   = !clear && pressed && !pressed_prev_q;
		release_edge = !clear && !pressed && pressed_prev_q;

		pressed_prev_nx = clear ? pressed_prev_q : pressed;

		if (clear) begin
			press_start_nx = now_q;
		end else if (press_edge) begin
			press_start_nx = now_inc;
		end else begin
			press_start_nx = press_start_q;
		end
		press_end_nx = release_edge ? now_inc : press_end_q;
		if (clear || press_edge) begin
			press_run_nx = 1'b1;
		end else if (release_edge) begin
			press_run_nx = 1'b0;
		end else begin
			press_run_nx = press_run_q;
		end

		if (clear) begin
			release_start_nx = now_q;
		end else if (release_edge) begin
			release_start_nx = now_inc;
		end else begin
			release_start_nx = release_start_q;
		end
		release_run_nx = clear || release_edge || release_run_q;

		press_cnt_nx   = clear ? '0 :
			(press_edge ? press_cnt_q + COUNT_BITS'(1) : press_cnt_q);
		release_cnt_nx = clear ? '0 :
			(release_edge ? release_cnt_q + COUNT_BITS'(1) : release_cnt_q);

		// Press and release elapsed times.
		ptime = (press_run_nx ? now_nx : press_end_nx) - press_start_nx;
		rtime = (pressed_prev_nx || !release_run_nx) ? '0 : now_nx - release_start_nx;
	end

	// Short and long press classification; a clear leaves it untouched.
	always_comb begin
		ge_short = CMP_W'(ptime) >= CMP_W'(short_max_ms);
		le_short = CMP_W'(ptime) <= CMP_W'(short_max_ms);
		ge_long  = CMP_W'(ptime) >= CMP_W'(long_min_ms);
		le_long  = CMP_W'(ptime) <= CMP_W'(long_min_ms);

		short_kept = (pressed && ge_short) ? '0 : short_cnt_q;
		short_win  = !pressed && le_short;
		short_bump = !clear && short_win && !short_win_q;

		long_hold = pressed && ge_long;
		long_bump = !clear && long_hold && !long_hold_q;
		long_kept = long_bump ? long_cnt_q + COUNT_BITS'(1) : long_cnt_q;

		if (clear) begin
			short_cnt_nx = short_cnt_q;
			long_cnt_nx  = long_cnt_q;
			short_win_nx = short_win_q;
			long_hold_nx = long_hold_q;
		end else begin
			short_cnt_nx = short_bump ? short_kept + COUNT_BITS'(1) : short_kept;
			long_cnt_nx  = (!pressed && le_long) ? '0 : long_kept;
			short_win_nx = short_win;
			long_hold_nx = long_hold;
		end
	end

	// State update when an item is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q           <= '0;
			pressed_prev_q  <= 1'b0;
			press_start_q   <= '0;
			press_end_q     <= '0;
			press_run_q     <= 1'b1;
			release_start_q <= '0;
			release_run_q   <= 1'b0;
			press_cnt_q     <= '0;
			release_cnt_q   <= '0;
			short_cnt_q     <= '0;
			long_cnt_q      <= '0;
			short_win_q     <= 1'b1;
			long_hold_q     <= 1'b0;
		end else if (step) begin
			now_q           <= now_nx;
			pressed_prev_q  <= pressed_prev_nx;
			press_start_q   <= press_start_nx;
			press_end_q     <= press_end_nx;
			press_run_q     <= press_run_nx;
			release_start_q <= release_start_nx;
			release_run_q   <= release_run_nx;
			press_cnt_q     <= press_cnt_nx;
			release_cnt_q   <= release_cnt_nx;
			short_cnt_q     <= short_cnt_nx;
			long_cnt_q      <= long_cnt_nx;
			short_win_q     <= short_win_nx;
			long_hold_q     <= long_hold_nx;
		end
	end

	// Result of the item being processed.
	always_comb begin
		flags.is_pressed   = pressed_prev_nx;
		flags.press_edge   = press_edge;
		flags.release_edge = release_edge;
		flags.short_bumped = short_bump;
		flags.long_bumped  = long_bump;
		press_time_ms      = ptime;
		release_time_ms    = rtime;
		press_total        = press_cnt_nx;
		release_total      = release_cnt_nx;
		short_total        = short_cnt_nx;
		long_total         = long_cnt_nx;
	end

endmodule

[src/button_press_classifier_unit.sv]
// Datapath: a beat accepted into the input register is loaded into the output
// register when the input register advances, which can wait on a stalled
// output; m_tvalid then rises and the beat is held there until it is taken.
// Throughput: one beat per cycle; the input register advances whenever the
// output register is empty or being taken, so only a stalled output slows it.
// Reset: arst_n clears all timers, counters and valid flags asynchronously and
// loads the configuration defaults (active low, short 500 ms, long 1000 ms).
`timescale 1ns / 1ps

module button_press_classifier_unit import bpc_pkg::*; #(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int OUT_BITS  = 5 + 2 * TIME_BITS + 4 * COUNT_BITS,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration write port.
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	// Input stream.
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,  // [0] pin_level, rest zero
	input  logic                     s_tuser,  // [0] command
	// Result stream.
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// From bit 0: is_pressed, press_edge, release_edge, press_time_ms,
	// release_time_ms, press_total, release_total, short_total, long_total,
	// short_bumped, long_bumped, zero fill.
	output logic [OUT_W-1:0]         m_tdata
);

	// Configuration registers.
	logic                active_low_q;
	logic [THR_BITS-1:0] short_max_q;
	logic [THR_BITS-1:0] long_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q <= ACTIVE_LOW_RST;
			short_max_q  <= SHORT_MAX_MS_RST;
			long_min_q   <= LONG_MIN_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_LOW:   active_low_q <= cfg_data[0];
				REG_SHORT_MAX_MS: short_max_q  <= cfg_data[THR_BITS-1:0];
				REG_LONG_MIN_MS:  long_min_q   <= cfg_data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Input register and flow control.
	logic valid_s1;
	logic cmd_s1;
	logic pin_s1;
	logic advance;
	logic out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= s_tuser;
			pin_s1 <= s_tdata[0];
		end
	end

	// Classifier state and result logic.
	bpc_flags_t            flags;
	logic [TIME_BITS-1:0]  press_time_ms;
	logic [TIME_BITS-1:0]  release_time_ms;
	logic [COUNT_BITS-1:0] press_total;
	logic [COUNT_BITS-1:0] release_total;
	logic [COUNT_BITS-1:0] short_total;
	logic [COUNT_BITS-1:0] long_total;

	bpc_core #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.command         (cmd_s1),
		.pin_level       (pin_s1),
		.active_low      (active_low_q),
		.short_max_ms    (short_max_q),
		.long_min_ms     (long_min_q),
		.flags           (flags),
		.press_time_ms   (press_time_ms),
		.release_time_ms (release_time_ms),
		.press_total     (press_total),
		.release_total   (release_total),
		.short_total     (short_total),
		.long_total      (long_total)
	);

	// Output register.
	logic [OUT_BITS-1:0] packed_result;
	logic [OUT_W-1:0]    out_data_q;

	assign packed_result = {flags.long_bumped, flags.short_bumped, long_total, short_total,
		release_total, press_total, release_time_ms, press_time_ms,
		flags.release_edge, flags.press_edge, flags.is_pressed};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= OUT_W'(packed_result);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[src/bpc_checker.sv]
// Port-level checks for button_press_classifier_unit, bound to the top level.
// Depends on bpc_pkg for the default widths.
`timescale 1ns / 1ps

module bpc_checker import bpc_pkg::*; #(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int OUT_BITS  = 5 + 2 * TIME_BITS + 4 * COUNT_BITS,
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int PT_LO = 3;
	localparam int RT_LO = 3 + TIME_BITS;

	logic                 is_pressed;
	logic                 press_edge;
	logic                 release_edge;
	logic [TIME_BITS-1:0] press_time;
	logic [TIME_BITS-1:0] release_time;

	assign is_pressed   = m_tdata[0];
	assign press_edge   = m_tdata[1];
	assign release_edge = m_tdata[2];
	assign press_time   = m_tdata[PT_LO +: TIME_BITS];
	assign release_time = m_tdata[RT_LO +: TIME_BITS];

	// A result beat stays offered until it is taken.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat withdrawn before it was taken");

	// A beat cannot carry both a press and a release.
	a_edge_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(press_edge && release_edge))
		else $error("press and release edge in one beat");

	// A press edge means pressed with the press timer just restarted.
	a_press_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && press_edge |-> is_pressed && press_time == '0)
		else $error("press edge without fresh press timer");

	// Release time reads zero while pressed and on the release tick itself.
	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (is_pressed || release_edge) |-> release_time == '0 && !(is_pressed && release_edge))
		else $error("release time not zero while pressed or at release");

endmodule

bind button_press_classifier_unit bpc_checker #(
	.TIME_BITS  (TIME_BITS),
	.COUNT_BITS (COUNT_BITS)
) u_bpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
